[src/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge, ignored while reset is active
`define PEHP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked on every rising edge, also during reset
`define PEHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PEHP_ASSERT(lbl, clk, rstn, prop, msg)
`define PEHP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/pehp_pkg.sv]
// shared types and constants of the pack entry header parser
`timescale 1ns / 1ps
package pehp_pkg;

  // size accumulator width, sizes are kept to this many bits
  localparam int unsigned SizeWidth = 64;
  localparam logic [63:0] SizeMask = {64{1'b1}} >> (64 - SizeWidth);

  // object type codes with special handling
  localparam logic [2:0] ObjTypeNone     = 3'd0;
  localparam logic [2:0] ObjTypeReserved = 3'd5;
  localparam logic [2:0] ObjTypeOfsDelta = 3'd6;

  // result status codes
  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusNeedMore  = 3'd1,
    StatusTooLong   = 3'd2,
    StatusBadType   = 3'd3,
    StatusBadOffset = 3'd4
  } status_e;

  // one input byte with its side information
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_entry;
    logic        last_available;
    logic [62:0] entry_offset;
  } item_t;

  // one decoded result
  typedef struct packed {
    status_e     status;
    logic [2:0]  object_type;
    logic [63:0] object_size;
    logic [62:0] delta_base;
    logic [4:0]  bytes_used;
  } result_t;

endpackage

[src/pack_entry_header_parser_unit.sv]
// top level of the pack entry header parser
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o   data_byte, first_of_entry,
//                                                 last_available, entry_offset
//   out      source     out_valid_o / out_stall_i status, object_type,
//                                                 object_size, delta_base, bytes_used
//
// one byte per cycle, back to back, while the input is not stalled; a taken byte is
// held in the input register, then decoded into the entry state and the result register
// asynchronous active-low reset clears the entry state and both valid flags
// a stalled result holds; input stalls only while both registers are occupied
// and the result is stalled
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pack_entry_header_parser_unit import pehp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_entry_i,
  input  logic        last_available_i,
  input  logic [62:0] entry_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  object_type_o,
  output logic [63:0] object_size_o,
  output logic [62:0] delta_base_o,
  output logic [4:0]  bytes_used_o
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    adv;
  result_t res;

  assign in_item.data_byte      = data_byte_i;
  assign in_item.first_of_entry = first_of_entry_i;
  assign in_item.last_available = last_available_i;
  assign in_item.entry_offset   = entry_offset_i;

  // input register
  pehp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .in_stall_o (in_stall_o),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  // decode and result register
  pehp_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_item_i   (s1_item),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign status_o      = res.status;
  assign object_type_o = res.object_type;
  assign object_size_o = res.object_size;
  assign delta_base_o  = res.delta_base;
  assign bytes_used_o  = res.bytes_used;

  // checks
  `PEHP_ASSERT(a_stall_cause, clk_i, rst_ni,
    in_stall_o |-> (s1_valid && out_valid_o && out_stall_i), "input stall without cause")
  `PEHP_ASSERT(a_base_ok, clk_i, rst_ni,
    (out_valid_o && (res.status == StatusOk) && (res.object_type == ObjTypeOfsDelta))
      |-> (delta_base_o != 63'd0), "accepted offset delta with zero base")
  `PEHP_ASSERT(a_base_zero, clk_i, rst_ni,
    (out_valid_o && !((res.status == StatusOk) && (res.object_type == ObjTypeOfsDelta)))
      |-> (delta_base_o == 63'd0), "base offset set on a non offset-delta result")
  `PEHP_ASSERT(a_too_long, clk_i, rst_ni,
    (out_valid_o && (res.status == StatusTooLong))
      |-> ((object_size_o == 64'd0) && (bytes_used_o == 5'd0)), "too-long result not cleared")

endmodule

[src/pehp_in_reg.sv]
// input register stage of the pack entry header parser
`timescale 1ns / 1ps
module pehp_in_reg import pehp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  in_stall_o,
  input  logic  adv_i,
  output logic  s1_valid_o,
  output item_t s1_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  // hold while a registered byte cannot move on
  assign in_stall_o = valid_q && !adv_i;
  assign load       = !in_stall_o;

  // next register contents
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = in_valid_i;
      item_d  = in_item_i;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

endmodule

[src/pehp_step.sv]
// per byte header and offset decode with entry state and result register
`timescale 1ns / 1ps
module pehp_step import pehp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s1_valid_i,
  input  item_t   s1_item_i,
  output logic    adv_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHdr  = 2'd1,
    PhOfs  = 2'd2,
    PhDone = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [63:0] size_q, size_d;
  logic [6:0]  shift_q, shift_d;
  logic [2:0]  type_q, type_d;
  logic [63:0] ofs_q, ofs_d;
  logic [62:0] start_q, start_d;
  logic [4:0]  count_q, count_d;
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;

  logic        take;
  logic        emit;
  logic        hdr_end;
  logic [7:0]  b;
  logic [4:0]  count_inc;
  logic [63:0] ofs_shift;
  logic [63:0] ofs_inc;
  logic [64:0] diff;
  logic        ofs_ge;

  // result register frees when empty or being drained
  assign adv_o = !res_valid_q || !out_stall_i;
  assign take  = s1_valid_i && adv_o;
  assign b     = s1_item_i.data_byte;

  // datapath helpers
  assign count_inc = (count_q == 5'd31) ? count_q : count_q + 5'd1;
  assign ofs_shift = {ofs_q[56:0], b[6:0]};
  assign ofs_inc   = ofs_shift + 64'd1;
  assign diff      = {2'b00, start_q} - {1'b0, ofs_shift};
  assign ofs_ge    = diff[64] || (diff[63:0] == 64'd0);

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    shift_d     = shift_q;
    type_d      = type_q;
    ofs_d       = ofs_q;
    start_d     = start_q;
    count_d     = count_q;
    res_d       = res_q;
    emit        = 1'b0;
    hdr_end     = 1'b0;
    res_valid_d = res_valid_q && out_stall_i;

    if (take) begin
      if (s1_item_i.first_of_entry) begin
        // first header byte: type and low size nibble
        start_d = s1_item_i.entry_offset;
        type_d  = b[6:4];
        size_d  = {60'd0, b[3:0]};
        shift_d = 7'd4;
        ofs_d   = 64'd0;
        count_d = 5'd1;
        if (b[7]) begin
          if (s1_item_i.last_available) begin
            emit               = 1'b1;
            res_d.status       = StatusNeedMore;
            res_d.object_size  = size_d & SizeMask;
            res_d.delta_base   = '0;
            res_d.bytes_used   = count_d;
          end else begin
            phase_d = PhHdr;
          end
        end else begin
          hdr_end = 1'b1;
        end
      end else begin
        case (phase_q)
          PhHdr: begin
            if (shift_q >= 7'(SizeWidth)) begin
              emit              = 1'b1;
              res_d.status      = StatusTooLong;
              res_d.object_size = '0;
              res_d.delta_base  = '0;
              res_d.bytes_used  = '0;
            end else begin
              // size chunks never overlap, so or-ing equals adding
              size_d  = (size_q | ({57'd0, b[6:0]} << shift_q)) & SizeMask;
              shift_d = shift_q + 7'd7;
              count_d = count_inc;
              if (b[7]) begin
                if (s1_item_i.last_available) begin
                  emit              = 1'b1;
                  res_d.status      = StatusNeedMore;
                  res_d.object_size = size_d & SizeMask;
                  res_d.delta_base  = '0;
                  res_d.bytes_used  = count_d;
                end
              end else begin
                hdr_end = 1'b1;
              end
            end
          end
          PhOfs: begin
            // big-endian offset with +1 bias per continuation
            count_d = count_inc;
            ofs_d   = ofs_shift;
            res_d.object_size = size_q & SizeMask;
            res_d.bytes_used  = count_d;
            res_d.delta_base  = '0;
            if (b[7]) begin
              if (s1_item_i.last_available) begin
                emit         = 1'b1;
                res_d.status = StatusNeedMore;
              end else begin
                ofs_d = ofs_inc;
                if ((ofs_inc == 64'd0) || (ofs_inc[63:57] != 7'd0)) begin
                  emit         = 1'b1;
                  res_d.status = StatusBadOffset;
                end
              end
            end else begin
              emit = 1'b1;
              if ((ofs_shift == 64'd0) || ofs_ge) begin
                res_d.status = StatusBadOffset;
              end else begin
                res_d.status     = StatusOk;
                res_d.delta_base = diff[62:0];
              end
            end
          end
          default: begin
          end
        endcase
      end

      // end of the size varint
      if (hdr_end) begin
        res_d.object_size = size_d & SizeMask;
        res_d.delta_base  = '0;
        res_d.bytes_used  = count_d;
        if ((type_d == ObjTypeNone) || (type_d == ObjTypeReserved)) begin
          emit         = 1'b1;
          res_d.status = StatusBadType;
        end else if (type_d == ObjTypeOfsDelta) begin
          if (s1_item_i.last_available) begin
            emit         = 1'b1;
            res_d.status = StatusNeedMore;
          end else begin
            ofs_d   = 64'd0;
            phase_d = PhOfs;
          end
        end else begin
          emit         = 1'b1;
          res_d.status = StatusOk;
        end
      end

      if (emit) begin
        phase_d           = PhDone;
        res_d.object_type = type_d;
        res_valid_d       = 1'b1;
      end
    end
  end

  // entry state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      size_q      <= '0;
      shift_q     <= '0;
      type_q      <= '0;
      ofs_q       <= '0;
      start_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      size_q      <= size_d;
      shift_q     <= shift_d;
      type_q      <= type_d;
      ofs_q       <= ofs_d;
      start_q     <= start_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[tb/sv/pack_entry_header_parser_unit_test.sv]
// self-checking testbench for the pack entry header parser, predictor-based
`timescale 1ns / 1ps
module pack_entry_header_parser_unit_test import pehp_pkg::*;;

  // where the predictor stands inside the current entry
  typedef enum logic [1:0] {
    ScanIdle,
    ScanHeader,
    ScanOffset,
    ScanDone
  } scan_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  item_t       drive_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [2:0]  object_type;
  logic [63:0] object_size;
  logic [62:0] delta_base;
  logic [4:0]  bytes_used;

  // idling knobs, changed only while the pipe is drained
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // bookkeeping shared by driver, monitor and stimulus
  item_t   entry_bytes_q[$];
  result_t header_results_q[$];
  int      bytes_queued = 0;
  int      bytes_taken = 0;
  int      stim_bytes = 0;
  int      mismatches = 0;

  // predictor state
  scan_e       scan_state = ScanIdle;
  logic [63:0] size_acc = '0;
  int unsigned size_shift = 0;
  logic [2:0]  obj_type = '0;
  logic [63:0] delta_acc = '0;
  logic [62:0] entry_base = '0;
  logic [4:0]  byte_total = '0;

  pack_entry_header_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (drive_item.data_byte),
    .first_of_entry_i(drive_item.first_of_entry),
    .last_available_i(drive_item.last_available),
    .entry_offset_i  (drive_item.entry_offset),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .object_type_o   (object_type),
    .object_size_o   (object_size),
    .delta_base_o    (delta_base),
    .bytes_used_o    (bytes_used)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // record the decoded header of the current entry and close it
  task automatic report_header(status_e st, logic [63:0] size_val, logic [62:0] base_val,
                               logic [4:0] used);
    result_t r;
    r.status      = st;
    r.object_type = obj_type;
    r.object_size = size_val & SizeMask;
    r.delta_base  = base_val;
    r.bytes_used  = used;
    header_results_q.push_back(r);
    scan_state = ScanDone;
  endtask

  // header size varint is complete: classify the type
  task automatic close_header(logic is_last);
    if (obj_type == ObjTypeNone || obj_type == ObjTypeReserved) begin
      report_header(StatusBadType, size_acc, '0, byte_total);
    end else if (obj_type == ObjTypeOfsDelta) begin
      if (is_last) begin
        report_header(StatusNeedMore, size_acc, '0, byte_total);
      end else begin
        delta_acc  = '0;
        scan_state = ScanOffset;
      end
    end else begin
      report_header(StatusOk, size_acc, '0, byte_total);
    end
  endtask

  // advance the header decode by one accepted byte
  task automatic decode_byte(item_t it);
    logic [7:0] b;
    b = it.data_byte;
    if (it.first_of_entry) begin
      entry_base = it.entry_offset;
      obj_type   = b[6:4];
      size_acc   = {60'd0, b[3:0]};
      size_shift = 4;
      delta_acc  = '0;
      byte_total = 5'd1;
      if (!b[7]) begin
        close_header(it.last_available);
      end else if (it.last_available) begin
        report_header(StatusNeedMore, size_acc, '0, byte_total);
      end else begin
        scan_state = ScanHeader;
      end
    end else if (scan_state == ScanHeader) begin
      if (size_shift >= SizeWidth) begin
        report_header(StatusTooLong, '0, '0, '0);
      end else begin
        size_acc = (size_acc + ({57'd0, b[6:0]} << size_shift)) & SizeMask;
        size_shift += 7;
        if (byte_total != 5'd31) byte_total++;
        if (!b[7]) begin
          close_header(it.last_available);
        end else if (it.last_available) begin
          report_header(StatusNeedMore, size_acc, '0, byte_total);
        end
      end
    end else if (scan_state == ScanOffset) begin
      if (byte_total != 5'd31) byte_total++;
      delta_acc = (delta_acc << 7) + {57'd0, b[6:0]};
      if (b[7]) begin
        if (it.last_available) begin
          report_header(StatusNeedMore, size_acc, '0, byte_total);
        end else begin
          // biased continuation, reject a distance that cannot fit
          delta_acc += 64'd1;
          if (delta_acc == '0 || delta_acc[63:57] != '0)
            report_header(StatusBadOffset, size_acc, '0, byte_total);
        end
      end else if (delta_acc == '0 || delta_acc >= {1'b0, entry_base}) begin
        report_header(StatusBadOffset, size_acc, '0, byte_total);
      end else begin
        report_header(StatusOk, size_acc, entry_base - delta_acc[62:0], byte_total);
      end
    end
  endtask

  // input driver: predict on each transaction, then offer the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      drive_item <= '0;
      scan_state = ScanIdle;
      size_acc   = '0;
      size_shift = 0;
      obj_type   = '0;
      delta_acc  = '0;
      entry_base = '0;
      byte_total = '0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(drive_item);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (entry_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item <= entry_bytes_q.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // output monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin : take_result
      result_t want;
      if (out_valid && !out_stall) begin
        if (header_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d type %0d size %0h",
                   $time, status, object_type, object_size);
          mismatches++;
        end else begin
          want = header_results_q.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("object_type", 64'(want.object_type), 64'(object_type));
          check_field("object_size", want.object_size, object_size);
          check_field("delta_base", 64'(want.delta_base), 64'(delta_base));
          check_field("bytes_used", 64'(want.bytes_used), 64'(bytes_used));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_byte(logic [7:0] b, logic is_first, logic is_last, logic [62:0] ofs);
    item_t it;
    it.data_byte      = b;
    it.first_of_entry = is_first;
    it.last_available = is_last;
    it.entry_offset   = ofs;
    entry_bytes_q.push_back(it);
    bytes_queued++;
  endtask

  // entry offsets spread over small, 32-bit, top and arbitrary magnitudes
  function automatic logic [62:0] pick_entry_offset();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(4))
      0:       return 63'($urandom_range(300));
      1:       return {31'd0, r[31:0]};
      2:       return '1;
      default: return r[62:0] >> $urandom_range(62);
    endcase
  endfunction

  // one entry: header varint, offset varint for offset deltas, maybe cut short
  task automatic queue_random_entry();
    logic [7:0]  seq[$];
    logic [7:0]  enc[$];
    logic [62:0] ofs;
    logic [63:0] d;
    logic [2:0]  kind;
    int unsigned span;
    int          n_size;
    int          n_keep;
    logic        cut_last;
    ofs  = pick_entry_offset();
    kind = $urandom_range(1) ? ObjTypeOfsDelta : 3'($urandom_range(7));
    // mostly short sizes, now and then up to and past the 64-bit limit
    n_size = ($urandom_range(9) == 0) ? $urandom_range(7, 11) : $urandom_range(3);
    seq.push_back({n_size != 0, kind, 4'($urandom)});
    for (int i = 1; i <= n_size; i++) seq.push_back({i != n_size, 7'($urandom)});
    if (kind == ObjTypeOfsDelta) begin
      case ($urandom_range(5))
        0: begin
          // distance zero or reaching to or past the start of the pack
          d = ($urandom_range(3) == 0) ? 64'd0 : {1'b0, ofs} + 64'($urandom_range(3));
        end
        1: begin
          // run of continuations that overflows the distance
          repeat ($urandom_range(9, 11)) seq.push_back(8'hff);
          seq.push_back({1'b0, 7'($urandom)});
        end
        2: begin
          repeat ($urandom_range(4)) seq.push_back({1'b1, 7'($urandom)});
          seq.push_back({1'b0, 7'($urandom)});
        end
        default: begin
          if (ofs < 63'd2) begin
            d = '0;
          end else if ($urandom_range(1)) begin
            span = (ofs > 63'd1000) ? 999 : int'(ofs) - 1;
            d = 64'($urandom_range(1, span));
          end else begin
            d = {$urandom, $urandom} % {1'b0, ofs - 63'd1} + 64'd1;
          end
        end
      endcase
      if (seq[seq.size() - 1][7] || seq.size() == n_size + 1) begin
        // big-endian varint with +1 bias on each continuation
        enc.push_front({1'b0, d[6:0]});
        d = d >> 7;
        while (d != 0) begin
          d = d - 64'd1;
          enc.push_front({1'b1, d[6:0]});
          d = d >> 7;
        end
        seq = {seq, enc};
      end
    end
    // data may run out early, or the entry may be abandoned for the next one
    n_keep   = seq.size();
    cut_last = ($urandom_range(3) == 0);
    if ($urandom_range(4) == 0) n_keep = $urandom_range(1, seq.size());
    for (int i = 0; i < n_keep; i++)
      queue_byte(seq[i], i == 0, cut_last && i == n_keep - 1,
                 (i == 0) ? ofs : pick_entry_offset());
    stim_bytes += n_keep;
    // stray bytes between entries are ignored by the block once the entry has its result
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(1, 3))
        queue_byte(8'($urandom), 1'b0, 1'($urandom), pick_entry_offset());
  endtask

  // sender holds off until every queued byte is taken and every result is back
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || header_results_q.size() != 0) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed entries
    queue_byte(8'h00, 1'b0, 1'b0, '0);      // byte outside an entry
    queue_byte(8'h10, 1'b1, 1'b0, '0);      // object of type 1, size zero
    queue_byte(8'h0f, 1'b1, 1'b0, 63'd5);   // type none
    queue_byte(8'h5f, 1'b1, 1'b1, 63'd6);   // reserved type
    queue_byte(8'h7a, 1'b1, 1'b0, '1);      // reference delta at the top offset
    queue_byte(8'h60, 1'b1, 1'b0, 63'd10);  // offset delta, base 9
    queue_byte(8'h01, 1'b0, 1'b0, '0);
    queue_byte(8'h60, 1'b1, 1'b0, 63'd10);  // distance equal to entry offset
    queue_byte(8'h0a, 1'b0, 1'b0, '0);
    queue_byte(8'h65, 1'b1, 1'b1, 63'd3);   // offset delta with no offset bytes left
    queue_byte(8'h9f, 1'b1, 1'b1, '0);      // header cut after its first byte
    queue_byte(8'h9f, 1'b1, 1'b0, '0);      // new entry starts mid header
    queue_byte(8'h20, 1'b1, 1'b0, 63'd1);
    queue_byte(8'hbf, 1'b1, 1'b0, '0);      // header runs past 64 bits
    repeat (9) queue_byte(8'hff, 1'b0, 1'b0, '0);
    queue_byte(8'h7f, 1'b0, 1'b0, '0);
    wait_drained();

    // random entries under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
      stim_bytes = 0;
      while (stim_bytes < 150) queue_random_entry();
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && header_results_q.size() == 0) begin
      $display("[pack_entry_header_parser_unit] OK");
    end else begin
      $display("[pack_entry_header_parser_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("[pack_entry_header_parser_unit] ERROR");
    $finish;
  end

endmodule
